>>> rtl/uart8n1_pkg.sv
// Shared types and constants for the 8N1 UART transceiver.
// No dependencies; imported by the channel interfaces and the top level.
package uart8n1_pkg;

  localparam int unsigned BIT_PERIOD_W = 16;
  localparam int unsigned DATA_W       = 8;
  localparam int unsigned BIT_CNT_W    = 4;

  localparam logic [BIT_PERIOD_W-1:0] BIT_PERIOD_RST = 16'd104;

  // Transmit bit counter: bits finished so far
  localparam logic [BIT_CNT_W-1:0] TX_LAST_DATA = 4'd8;
  localparam logic [BIT_CNT_W-1:0] TX_STOP      = 4'd9;

  // Receive counters: data bits, then trailing bit periods
  localparam logic [BIT_CNT_W-1:0] RX_DATA_BITS  = 4'd8;
  localparam logic [BIT_CNT_W-1:0] RX_TRAIL_BITS = 4'd2;

  // One result transaction
  typedef struct packed {
    logic              tx_line;
    logic              tx_busy;
    logic              rx_valid;
    logic [DATA_W-1:0] rx_data;
  } uart8n1_res_t;

endpackage

>>> rtl/uart8n1_in_if.sv
// Input channel: one clock tick of line sampling plus a transmit request.
// Depends on uart8n1_pkg.
interface uart8n1_in_if
  import uart8n1_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              rx_line;
  logic              tx_start;
  logic [DATA_W-1:0] tx_byte;

  modport source (output valid, rx_line, tx_start, tx_byte, input ready);
  modport sink   (input valid, rx_line, tx_start, tx_byte, output ready);
endinterface

>>> rtl/uart8n1_out_if.sv
// Result channel: line levels and received byte for one tick.
// Depends on uart8n1_pkg.
interface uart8n1_out_if
  import uart8n1_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              tx_line;
  logic              tx_busy;
  logic              rx_valid;
  logic [DATA_W-1:0] rx_data;

  modport source (output valid, tx_line, tx_busy, rx_valid, rx_data, input ready);
  modport sink   (input valid, tx_line, tx_busy, rx_valid, rx_data, output ready);
endinterface

>>> rtl/uart_8n1_transceiver_top.sv
// Bit-timed 8N1 UART transceiver: transmitter, receiver and output skid stage.
// Depends on uart8n1_pkg, uart8n1_in_if and uart8n1_out_if.
//
// Usage:
//   in_ch  : one transaction per clock tick of the serial timebase, carrying the
//            sampled receive line, a transmit request and the byte to send.
//   out_ch : one transaction per input transaction: transmit line level, busy
//            flag, and a received byte flagged by rx_valid (rx_data 0 otherwise).
//   cfg_we/cfg_wdata : writes bit_period (ticks per serial bit); write only
//            while the block is idle.
//   Each accepted transaction updates the UART state in the same cycle and its
//   result appears on out_ch the next cycle unless out_ch stalls; throughput is one
//   transaction per cycle while out_ch does not stall, set by the single state/result register stage.
//   A two-entry output stage (result register plus skid register) keeps in_ch
//   ready driven from a register; when out_ch stalls, one further transaction
//   is taken into the skid register and in_ch ready then drops until the
//   receiver takes a result.
//   Reset (rst_n low, synchronous) sets bit_period to 104, idles both
//   directions with the transmit line high, and empties the output stage.
module uart_8n1_transceiver_top
  import uart8n1_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  uart8n1_in_if.sink              in_ch,
  uart8n1_out_if.source           out_ch,
  input  logic                    cfg_we,
  input  logic [BIT_PERIOD_W-1:0] cfg_wdata
);

  typedef enum logic [1:0] {
    RX_IDLE  = 2'd0,
    RX_DATA  = 2'd1,
    RX_TRAIL = 2'd2
  } rx_phase_t;

  logic [BIT_PERIOD_W-1:0] bit_period_r;

  logic [DATA_W-1:0]       tx_shift_r,     tx_shift_nxt;
  logic [BIT_CNT_W-1:0]    tx_bit_count_r, tx_bit_count_nxt;
  logic [BIT_PERIOD_W-1:0] tx_timer_r,     tx_timer_nxt;
  logic                    tx_active_r,    tx_active_nxt;
  logic                    tx_level_r,     tx_level_nxt;

  logic [DATA_W-1:0]       rx_shift_r,     rx_shift_nxt;
  logic [BIT_CNT_W-1:0]    rx_bit_count_r, rx_bit_count_nxt;
  logic [BIT_PERIOD_W-1:0] rx_timer_r,     rx_timer_nxt;
  rx_phase_t               rx_phase_r,     rx_phase_nxt;

  logic [BIT_PERIOD_W-1:0] tx_timer_inc, rx_timer_inc;
  logic                    tx_bit_end,   rx_bit_end;
  logic [BIT_CNT_W-1:0]    tx_cnt_inc,   rx_cnt_inc;
  logic                    rx_deliver;

  uart8n1_res_t            res;
  uart8n1_res_t            out_r, skid_r;
  logic                    out_valid_r, skid_valid_r;
  logic                    accept;

  // Handshake: ready comes straight from the skid register
  assign in_ch.ready = !skid_valid_r;
  assign accept      = in_ch.valid && in_ch.ready;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_period_r <= BIT_PERIOD_RST;
    end else if (cfg_we) begin
      bit_period_r <= cfg_wdata;
    end
  end

  // Bit timers: a bit ends once the count reaches the period or wraps
  assign tx_timer_inc = tx_timer_r + 1'b1;
  assign rx_timer_inc = rx_timer_r + 1'b1;
  assign tx_bit_end   = (tx_timer_inc >= bit_period_r) || (tx_timer_inc == '0);
  assign rx_bit_end   = (rx_timer_inc >= bit_period_r) || (rx_timer_inc == '0);
  assign tx_cnt_inc   = tx_bit_count_r + 1'b1;
  assign rx_cnt_inc   = rx_bit_count_r + 1'b1;

  // Transmitter next state
  always_comb begin
    tx_shift_nxt     = tx_shift_r;
    tx_bit_count_nxt = tx_bit_count_r;
    tx_timer_nxt     = tx_timer_r;
    tx_active_nxt    = tx_active_r;
    tx_level_nxt     = tx_level_r;
    if (!tx_active_r) begin
      // start bit goes out on the request tick
      if (in_ch.tx_start) begin
        tx_active_nxt    = 1'b1;
        tx_level_nxt     = 1'b0;
        tx_shift_nxt     = in_ch.tx_byte;
        tx_bit_count_nxt = '0;
        tx_timer_nxt     = '0;
      end
    end else if (!tx_bit_end) begin
      tx_timer_nxt = tx_timer_inc;
    end else begin
      tx_timer_nxt     = '0;
      tx_bit_count_nxt = tx_cnt_inc;
      if (tx_cnt_inc <= TX_LAST_DATA) begin
        tx_level_nxt = tx_shift_r[0];
        tx_shift_nxt = tx_shift_r >> 1;
      end else if (tx_cnt_inc == TX_STOP) begin
        tx_level_nxt = 1'b1;
      end else begin
        tx_active_nxt    = 1'b0;
        tx_level_nxt     = 1'b1;
        tx_bit_count_nxt = '0;
      end
    end
  end

  // Receiver next state
  always_comb begin
    rx_shift_nxt     = rx_shift_r;
    rx_bit_count_nxt = rx_bit_count_r;
    rx_timer_nxt     = rx_timer_r;
    rx_phase_nxt     = rx_phase_r;
    rx_deliver       = 1'b0;
    case (rx_phase_r)
      RX_DATA: begin
        if (rx_bit_end) begin
          rx_timer_nxt = '0;
          rx_shift_nxt = rx_shift_r;
          rx_shift_nxt[rx_bit_count_r[2:0]] = rx_shift_r[rx_bit_count_r[2:0]] | in_ch.rx_line;
          rx_bit_count_nxt = rx_cnt_inc;
          if (rx_cnt_inc >= RX_DATA_BITS) begin
            rx_phase_nxt     = RX_TRAIL;
            rx_bit_count_nxt = '0;
          end
        end else begin
          rx_timer_nxt = rx_timer_inc;
        end
      end
      RX_TRAIL: begin
        if (rx_bit_end) begin
          rx_timer_nxt     = '0;
          rx_bit_count_nxt = rx_cnt_inc;
          if (rx_cnt_inc >= RX_TRAIL_BITS) begin
            rx_deliver       = 1'b1;
            rx_phase_nxt     = RX_IDLE;
            rx_bit_count_nxt = '0;
          end
        end else begin
          rx_timer_nxt = rx_timer_inc;
        end
      end
      default: begin
        // idle, and the unused code: wait for a low line
        rx_phase_nxt = RX_IDLE;
        if (!in_ch.rx_line) begin
          rx_phase_nxt     = RX_DATA;
          rx_timer_nxt     = '0;
          rx_bit_count_nxt = '0;
          rx_shift_nxt     = '0;
        end
      end
    endcase
  end

  // Result of this tick, from the updated state
  always_comb begin
    res.tx_line  = tx_level_nxt;
    res.tx_busy  = tx_active_nxt;
    res.rx_valid = rx_deliver;
    res.rx_data  = rx_deliver ? rx_shift_r : '0;
  end

  // UART state, advanced once per accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_shift_r     <= '0;
      tx_bit_count_r <= '0;
      tx_timer_r     <= '0;
      tx_active_r    <= 1'b0;
      tx_level_r     <= 1'b1;
      rx_shift_r     <= '0;
      rx_bit_count_r <= '0;
      rx_timer_r     <= '0;
      rx_phase_r     <= RX_IDLE;
    end else if (accept) begin
      tx_shift_r     <= tx_shift_nxt;
      tx_bit_count_r <= tx_bit_count_nxt;
      tx_timer_r     <= tx_timer_nxt;
      tx_active_r    <= tx_active_nxt;
      tx_level_r     <= tx_level_nxt;
      rx_shift_r     <= rx_shift_nxt;
      rx_bit_count_r <= rx_bit_count_nxt;
      rx_timer_r     <= rx_timer_nxt;
      rx_phase_r     <= rx_phase_nxt;
    end
  end

  // Output register with skid register behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ch.ready) begin
      if (skid_valid_r) begin
        out_r        <= skid_r;
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_r       <= res;
        out_valid_r <= accept;
      end
    end else if (accept) begin
      skid_r       <= res;
      skid_valid_r <= 1'b1;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.tx_line  = out_r.tx_line;
  assign out_ch.tx_busy  = out_r.tx_busy;
  assign out_ch.rx_valid = out_r.rx_valid;
  assign out_ch.rx_data  = out_r.rx_data;

  // Skid register is only filled behind a stalled output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a result while output register is empty");

  // A stalled, full output stage holds everything
  a_full_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_ch.ready) |=> (skid_valid_r && $stable(skid_r) && $stable(out_r)))
    else $error("full output stage changed under stall");

  // Idle transmitter drives the line high
  a_tx_idle_high: assert property (@(posedge clk) disable iff (!rst_n)
    !tx_active_r |-> tx_level_r)
    else $error("transmit line low while transmitter idle");

  // Receive bit counter stays within its phase
  a_rx_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((rx_phase_r == RX_DATA) |-> (rx_bit_count_r < RX_DATA_BITS)) and
    ((rx_phase_r == RX_TRAIL) |-> (rx_bit_count_r < RX_TRAIL_BITS)))
    else $error("receive bit counter out of range");

  // Transmit counter never passes the stop bit while busy
  a_tx_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    tx_active_r |-> (tx_bit_count_r <= TX_STOP))
    else $error("transmit bit counter out of range");

endmodule
